### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with reset disable
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the default clock and reset of a module
`define ASSERT_CLK(label, prop, msg) \
    `ASSERT_SYNC(label, i_clk, i_rst_n, prop, msg)

`endif

### design/salsa_pkg.sv
package salsa_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_W       = $clog2(NUM_ROUNDS);
    localparam int WORD_W        = 32;
    localparam int STATE_WORDS   = 16;
    localparam int POS_W         = 4;
    localparam int QR_UNITS      = 4;
    localparam int STEP_W        = 2;
    localparam int KEY_REGS      = 4;
    localparam int CFG_W         = 64;
    localparam int CNT_W         = 64;
    localparam int PADDR_W       = 6;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

    localparam logic [POS_W-1:0]   LAST_POS   = 4'd15;
    localparam logic [STEP_W-1:0]  LAST_STEP  = 2'd3;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

    localparam int ROT_A = 7;
    localparam int ROT_B = 9;
    localparam int ROT_C = 13;
    localparam int ROT_D = 18;

    localparam logic [3:0][WORD_W-1:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_words;

    typedef struct packed {
        logic [KEY_REGS-1:0][CFG_W-1:0] key;
        logic [CFG_W-1:0]               nonce;
    } t_cfg;

    typedef struct packed {
        logic              load_init;
        logic              round_step;
        logic              final_add;
        logic              capture;
        logic              emit;
        logic              emit_held;
        logic              cnt_clear;
        logic              cnt_incr;
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  pos;
    } t_dp_cmd;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // word of column u at row offset k, diagonal order of the column round
    function automatic logic [POS_W-1:0] qr_idx(input int u, input int k);
        return POS_W'(4 * ((u + k) % 4) + u);
    endfunction

    function automatic t_words transpose(input t_words w);
        t_words t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[4*r+c] = w[4*c+r];
            end
        end
        return t;
    endfunction

    function automatic t_words build_init(input t_cfg cfg, input logic [CNT_W-1:0] cnt);
        t_words w;
        w[0]  = SIGMA[0];
        w[1]  = cfg.key[0][31:0];
        w[2]  = cfg.key[0][63:32];
        w[3]  = cfg.key[1][31:0];
        w[4]  = cfg.key[1][63:32];
        w[5]  = SIGMA[1];
        w[6]  = cfg.nonce[31:0];
        w[7]  = cfg.nonce[63:32];
        w[8]  = cnt[31:0];
        w[9]  = cnt[63:32];
        w[10] = SIGMA[2];
        w[11] = cfg.key[2][31:0];
        w[12] = cfg.key[2][63:32];
        w[13] = cfg.key[3][31:0];
        w[14] = cfg.key[3][63:32];
        w[15] = SIGMA[3];
        return w;
    endfunction

endpackage

### design/salsa_regs.sv
module salsa_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [salsa_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [salsa_pkg::CFG_W-1:0]    i_pwdata,
    output logic [salsa_pkg::CFG_W-1:0]    o_prdata,
    output logic                           o_pready,
    output salsa_pkg::t_cfg                o_cfg
);
    import salsa_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx      = i_paddr[PADDR_W-1:3];
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_KEY01: n_cfg.key[0] = i_pwdata;
                REG_KEY23: n_cfg.key[1] = i_pwdata;
                REG_KEY45: n_cfg.key[2] = i_pwdata;
                REG_KEY67: n_cfg.key[3] = i_pwdata;
                REG_NONCE: n_cfg.nonce  = i_pwdata;
                default:   n_cfg        = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_KEY01: o_prdata = r_cfg.key[0];
            REG_KEY23: o_prdata = r_cfg.key[1];
            REG_KEY45: o_prdata = r_cfg.key[2];
            REG_KEY67: o_prdata = r_cfg.key[3];
            REG_NONCE: o_prdata = r_cfg.nonce;
            default:   o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/salsa_dp.sv
module salsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  salsa_pkg::t_dp_cmd            i_cmd,
    input  salsa_pkg::t_cfg               i_cfg,
    input  logic [salsa_pkg::WORD_W-1:0]  i_data,
    output logic [salsa_pkg::WORD_W-1:0]  o_out_word,
    output logic                          o_out_last
);
    import salsa_pkg::*;

    t_words             r_words;
    t_words             n_words;
    t_words             init_words;
    t_words             step_words;
    t_words             sum_words;
    logic [WORD_W-1:0]  r_data;
    logic [CNT_W-1:0]   r_counter;
    logic [CNT_W-1:0]   n_counter;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_last;
    logic [WORD_W-1:0]  src_word;

    assign init_words = build_init(i_cfg, r_counter);

    // four column quarter-round units, one add-rotate-xor step each per cycle
    always_comb begin
        step_words = r_words;
        for (int u = 0; u < QR_UNITS; u++) begin
            unique case (i_cmd.step)
                2'd0: step_words[qr_idx(u, 1)] = r_words[qr_idx(u, 1)]
                    ^ rotl(r_words[qr_idx(u, 0)] + r_words[qr_idx(u, 3)], ROT_A);
                2'd1: step_words[qr_idx(u, 2)] = r_words[qr_idx(u, 2)]
                    ^ rotl(r_words[qr_idx(u, 1)] + r_words[qr_idx(u, 0)], ROT_B);
                2'd2: step_words[qr_idx(u, 3)] = r_words[qr_idx(u, 3)]
                    ^ rotl(r_words[qr_idx(u, 2)] + r_words[qr_idx(u, 1)], ROT_C);
                2'd3: step_words[qr_idx(u, 0)] = r_words[qr_idx(u, 0)]
                    ^ rotl(r_words[qr_idx(u, 3)] + r_words[qr_idx(u, 2)], ROT_D);
                default: step_words = r_words;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < STATE_WORDS; i++) begin
            sum_words[i] = r_words[i] + init_words[i];
        end
    end

    // row round runs as a column round on the transposed state
    always_comb begin
        priority if (i_cmd.load_init) begin
            n_words = init_words;
        end else if (i_cmd.round_step) begin
            n_words = (i_cmd.step == LAST_STEP) ? transpose(step_words) : step_words;
        end else if (i_cmd.final_add) begin
            n_words = sum_words;
        end else begin
            n_words = r_words;
        end
    end

    always_comb begin
        priority if (i_cmd.cnt_clear) begin
            n_counter = '0;
        end else if (i_cmd.cnt_incr) begin
            n_counter = r_counter + CNT_W'(1);
        end else begin
            n_counter = r_counter;
        end
    end

    assign src_word = i_cmd.emit_held ? r_data : i_data;

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        if (i_cmd.capture) begin
            r_data <= i_data;
        end
        if (i_cmd.emit) begin
            r_out_word <= src_word ^ r_words[i_cmd.pos];
            r_out_last <= (i_cmd.pos == LAST_POS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

    assign o_out_word = r_out_word;
    assign o_out_last = r_out_last;

endmodule

### design/salsa_ctrl.sv
`include "assert_macros.svh"

module salsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_start,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output salsa_pkg::t_dp_cmd o_cmd
);
    import salsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [ROUND_W-1:0]  r_round;
    logic [ROUND_W-1:0]  n_round;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [POS_W-1:0]    eff_pos;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign eff_pos    = i_in_start ? '0 : r_pos;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_step      = r_step;
        n_round     = r_round;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        o_cmd.pos   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (o_in_ready && i_in_valid) begin
                    o_cmd.cnt_clear = i_in_start;
                    o_cmd.pos       = eff_pos;
                    if (eff_pos == '0) begin
                        o_cmd.capture = 1'b1;
                        n_pos         = '0;
                        n_state       = S_LOAD;
                    end else begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.cnt_incr = (eff_pos == LAST_POS);
                        n_out_valid    = 1'b1;
                        n_pos          = eff_pos + POS_W'(1);
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_init = 1'b1;
                n_step          = '0;
                n_round         = '0;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_step = 1'b1;
                n_step           = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_round = r_round + ROUND_W'(1);
                    if (r_round == LAST_ROUND) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                o_cmd.final_add = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_held = 1'b1;
                o_cmd.cnt_incr  = (r_pos == LAST_POS);
                n_out_valid     = 1'b1;
                n_pos           = r_pos + POS_W'(1);
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_step      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_step      <= n_step;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_emit_out_free, r_state == S_EMIT |-> !r_out_valid, "result register busy")
    `ASSERT_CLK(a_ready_only_idle, o_in_ready |-> r_state == S_IDLE, "input taken outside idle")
    `ASSERT_CLK(a_final_late, r_state == S_FINAL |-> $past(r_round) == LAST_ROUND, "early final add")
    `ASSERT_CLK(a_cnt_exclusive, !(o_cmd.cnt_clear && o_cmd.cnt_incr), "clear and increment")

endmodule

### design/salsa20_stream_cipher_unit.sv
// Salsa20/20 stream cipher, one 32-bit little-endian word per stream transfer. A word with
// tuser set restarts the message (block counter and word position to zero). The first word
// of every 64-byte block waits for a new keystream block: load, 80 round steps and a final
// add, done by four quarter-round units that each do one add-rotate-xor step per cycle
// (2 * DOUBLE_ROUNDS rounds of four steps). The other fifteen words of a block use that
// keystream block directly, each taken once the result register is free or being read out.
// tlast marks the sixteenth word of a block. Key and nonce are 64-bit registers at byte
// addresses 0, 8, 16, 24 (key) and 32 (nonce); write them only while no word is in flight.
module salsa20_stream_cipher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // data_word
    input  logic                            s_axis_tuser,  // start_of_message
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // result_word
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [salsa_pkg::PADDR_W-1:0]   paddr,
    input  logic [salsa_pkg::CFG_W-1:0]     pwdata,
    output logic [salsa_pkg::CFG_W-1:0]     prdata,
    output logic                            pready
);
    import salsa_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;

    salsa_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    salsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_start  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (dp_cmd)
    );

    salsa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_cfg      (cfg),
        .i_data     (s_axis_tdata),
        .o_out_word (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule
